@@ sv/rbi_pkg.sv @@
package rbi_pkg;

  // Quotient bits kept by the divider; anything at or above 2^QB saturates.
  localparam int QB = 31;
  // Remainder width in the divider; holds both af << FRACTION_BITS and ad << QB.
  localparam int RW = 63;
  // Width of the squared-diagonal sum (three squared box extents).
  localparam int SW = 67;
  // Width used for hit-point and widened-bound compares.
  localparam int CW = 72;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] hit_distance;
    logic [1:0]        entry_axis;
  } res_t;

  // Data that rides alongside an item through the whole pipeline.
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [1:0]       axis;
    logic             neg;
    logic             hit0;
  } sb_t;

  typedef struct packed {
    sb_t         sb;
    logic [32:0] af;
    logic [31:0] ad;
  } front_t;

  typedef struct packed {
    sb_t           sb;
    logic [QB-1:0] q;
    logic          sat;
  } div_t;

endpackage

@@ sv/rbi_front.sv @@
module rbi_front import rbi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ray_t             ray,
  input  logic [2:0][31:0] box_min,
  input  logic [2:0][31:0] box_max,
  output logic             out_valid,
  output front_t           out
);

  logic [2:0][31:0] o;
  logic [2:0][31:0] d;
  logic [2:0]       lt;
  logic [2:0]       gt;
  logic [2:0][32:0] af_c;
  logic [2:0][31:0] ad_c;
  logic [2:0]       cand_c;
  logic [2:0]       neg_c;

  assign o = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign d = {ray.direction_z, ray.direction_y, ray.direction_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lt[i] = $signed(o[i]) < $signed(box_min[i]);
      gt[i] = $signed(o[i]) > $signed(box_max[i]);
      if (lt[i]) begin
        af_c[i] = 33'($signed(box_min[i])) - 33'($signed(o[i]));
      end else begin
        af_c[i] = 33'($signed(o[i])) - 33'($signed(box_max[i]));
      end
      ad_c[i]   = d[i][31] ? 32'(-d[i]) : d[i];
      cand_c[i] = (lt[i] || gt[i]) && (d[i] != '0);
      neg_c[i]  = lt[i] == d[i][31];
    end
  end

  // Stage 1: slab tests and magnitudes.
  logic             s1_valid;
  logic [2:0][32:0] s1_af;
  logic [2:0][31:0] s1_ad;
  logic [2:0]       s1_cand;
  logic [2:0]       s1_neg;
  logic             s1_inside;
  logic [2:0][31:0] s1_o;
  logic [2:0][31:0] s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_af     <= af_c;
      s1_ad     <= ad_c;
      s1_cand   <= cand_c;
      s1_neg    <= neg_c;
      s1_inside <= ~|(lt | gt);
      s1_o      <= o;
      s1_d      <= d;
    end
  end

  // Stage 2: cross products that rank the candidate distances exactly.
  logic             s2_valid;
  logic [64:0]      p01, p10, p02, p20, p12, p21;
  logic [2:0][32:0] s2_af;
  logic [2:0][31:0] s2_ad;
  logic [2:0]       s2_cand;
  logic [2:0]       s2_neg;
  logic             s2_inside;
  logic [2:0][31:0] s2_o;
  logic [2:0][31:0] s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p01       <= 65'(s1_af[0]) * 65'(s1_ad[1]);
      p10       <= 65'(s1_af[1]) * 65'(s1_ad[0]);
      p02       <= 65'(s1_af[0]) * 65'(s1_ad[2]);
      p20       <= 65'(s1_af[2]) * 65'(s1_ad[0]);
      p12       <= 65'(s1_af[1]) * 65'(s1_ad[2]);
      p21       <= 65'(s1_af[2]) * 65'(s1_ad[1]);
      s2_af     <= s1_af;
      s2_ad     <= s1_ad;
      s2_cand   <= s1_cand;
      s2_neg    <= s1_neg;
      s2_inside <= s1_inside;
      s2_o      <= s1_o;
      s2_d      <= s1_d;
    end
  end

  // Stage 3: pick the entry plane. A later axis wins only when strictly farther.
  logic       g10, g20, g21;
  logic [1:0] sel;
  front_t     nxt;

  assign g10 = p10 > p01;
  assign g20 = p20 > p02;
  assign g21 = p21 > p12;

  always_comb begin
    sel = AXIS_NONE;
    if (s2_cand[0]) begin
      sel = AXIS_X;
    end
    if (s2_cand[1] && (sel == AXIS_NONE || g10)) begin
      sel = AXIS_Y;
    end
    if (s2_cand[2] && (sel == AXIS_NONE || (sel == AXIS_X ? g20 : g21))) begin
      sel = AXIS_Z;
    end
  end

  always_comb begin
    nxt.sb.o    = s2_o;
    nxt.sb.d    = s2_d;
    nxt.sb.axis = sel;
    nxt.sb.hit0 = s2_inside;
    case (sel)
      AXIS_X: begin
        nxt.af     = s2_af[0];
        nxt.ad     = s2_ad[0];
        nxt.sb.neg = s2_neg[0];
      end
      AXIS_Y: begin
        nxt.af     = s2_af[1];
        nxt.ad     = s2_ad[1];
        nxt.sb.neg = s2_neg[1];
      end
      AXIS_Z: begin
        nxt.af     = s2_af[2];
        nxt.ad     = s2_ad[2];
        nxt.sb.neg = s2_neg[2];
      end
      default: begin
        nxt.af     = '0;
        nxt.ad     = '0;
        nxt.sb.neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= nxt;
    end
  end

`ifndef SYNTHESIS
  // A chosen plane always has a nonzero distance and a nonzero direction.
  a_sel_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.sb.axis != AXIS_NONE |-> out.af != '0 && out.ad != '0)
    else $error("entry plane chosen with zero distance or direction");
`endif

endmodule

@@ sv/rbi_div.sv @@
module rbi_div import rbi_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  front_t in,
  output logic   out_valid,
  output div_t   out
);

  // Entry stage: scale the dividend and decide saturation up front, so the
  // remaining stages only need QB quotient bits.
  logic [RW-1:0] n_c;
  logic          sat_c;

  assign n_c   = RW'(in.af) << FRACTION_BITS;
  assign sat_c = n_c >= (RW'(in.ad) << QB);

  logic [QB:0]              v;
  logic [QB:0][RW-1:0]      rem;
  logic [QB:0][31:0]        ad;
  logic [QB:0][QB-1:0]      q;
  logic [QB:0]              sat;
  sb_t                      sb [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n_c;
      ad[0]  <= in.ad;
      q[0]   <= '0;
      sat[0] <= sat_c;
      sb[0]  <= in.sb;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(ad[j]) << K;
    assign ge = rem[j] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? rem[j] - sh : rem[j];
        q[j+1]   <= q[j] | (QB'(ge) << K);
        ad[j+1]  <= ad[j];
        sat[j+1] <= sat[j];
        sb[j+1]  <= sb[j];
      end
    end
  end

  assign out_valid = v[QB];
  assign out.sb    = sb[QB];
  assign out.q     = q[QB];
  assign out.sat   = sat[QB];

endmodule

@@ sv/rbi_check.sv @@
module rbi_check import rbi_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  div_t                 in,
  input  logic [2:0][CW-1:0]   bound_lo,
  input  logic [2:0][CW-1:0]   bound_hi,
  output logic                 out_valid,
  output res_t                 out
);

  function automatic logic [1:0] axis_next(input logic [1:0] a);
    case (a)
      AXIS_X:  axis_next = AXIS_Y;
      AXIS_Y:  axis_next = AXIS_Z;
      AXIS_Z:  axis_next = AXIS_X;
      default: axis_next = AXIS_X;
    endcase
  endfunction

  function automatic logic [1:0] axis_prev(input logic [1:0] a);
    case (a)
      AXIS_X:  axis_prev = AXIS_Z;
      AXIS_Y:  axis_prev = AXIS_X;
      AXIS_Z:  axis_prev = AXIS_Y;
      default: axis_prev = AXIS_X;
    endcase
  endfunction

  // Stage T: signed, saturated distance.
  logic        t_c_none;
  logic [31:0] t_c;

  assign t_c_none = in.sb.axis == AXIS_NONE;

  always_comb begin
    if (t_c_none) begin
      t_c = '0;
    end else if (in.sat) begin
      t_c = in.sb.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (in.sb.neg) begin
      t_c = 32'(-{1'b0, in.q});
    end else begin
      t_c = {1'b0, in.q};
    end
  end

  logic        t_valid;
  logic [31:0] t_t;
  sb_t         t_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (en) begin
      t_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_t  <= t_c;
      t_sb <= in.sb;
    end
  end

  // Stage M: travel along the two other axes.
  logic [1:0]  a1, a2;
  logic [31:0] mt, md1, md2;

  assign a1  = axis_next(t_sb.axis);
  assign a2  = axis_prev(t_sb.axis);
  assign mt  = t_t[31] ? 32'(-t_t) : t_t;
  assign md1 = t_sb.d[a1][31] ? 32'(-t_sb.d[a1]) : t_sb.d[a1];
  assign md2 = t_sb.d[a2][31] ? 32'(-t_sb.d[a2]) : t_sb.d[a2];

  logic        m_valid;
  logic [63:0] m_p1, m_p2;
  logic        m_n1, m_n2;
  logic [31:0] m_o1, m_o2;
  logic [1:0]  m_a1, m_a2;
  logic [31:0] m_t;
  logic [1:0]  m_axis;
  logic        m_hit0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_p1   <= 64'(mt) * 64'(md1);
      m_p2   <= 64'(mt) * 64'(md2);
      m_n1   <= t_t[31] != t_sb.d[a1][31];
      m_n2   <= t_t[31] != t_sb.d[a2][31];
      m_o1   <= t_sb.o[a1];
      m_o2   <= t_sb.o[a2];
      m_a1   <= a1;
      m_a2   <= a2;
      m_t    <= t_t;
      m_axis <= t_sb.axis;
      m_hit0 <= t_sb.hit0;
    end
  end

  // Stage H: hit point coordinates at full width.
  logic [CW-1:0] pm1, pm2, h1_c, h2_c;

  assign pm1  = CW'(m_p1 >> FRACTION_BITS);
  assign pm2  = CW'(m_p2 >> FRACTION_BITS);
  assign h1_c = CW'($signed(m_o1)) + (m_n1 ? CW'(-pm1) : pm1);
  assign h2_c = CW'($signed(m_o2)) + (m_n2 ? CW'(-pm2) : pm2);

  logic          h_valid;
  logic [CW-1:0] h_h1, h_h2;
  logic [1:0]    h_a1, h_a2;
  logic [31:0]   h_t;
  logic [1:0]    h_axis;
  logic          h_hit0;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_h1   <= h1_c;
      h_h2   <= h2_c;
      h_a1   <= m_a1;
      h_a2   <= m_a2;
      h_t    <= m_t;
      h_axis <= m_axis;
      h_hit0 <= m_hit0;
    end
  end

  // Output stage: compare against the widened box.
  logic ok1, ok2;
  res_t res_c;

  assign ok1 = !($signed(h_h1) < $signed(bound_lo[h_a1]))
            && !($signed(h_h1) > $signed(bound_hi[h_a1]));
  assign ok2 = !($signed(h_h2) < $signed(bound_lo[h_a2]))
            && !($signed(h_h2) > $signed(bound_hi[h_a2]));

  always_comb begin
    res_c.hit          = (h_axis == AXIS_NONE) ? h_hit0 : (ok1 && ok2);
    res_c.hit_distance = h_t;
    res_c.entry_axis   = h_axis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= res_c;
    end
  end

endmodule

@@ sv/ray_box_intersection.sv @@
// Pipeline: 3 front stages, 1 + 31 divider stages (one quotient bit each),
//   and 4 hit-check stages.
// Throughput: one item per cycle when the output is not stalled; the one-bit-per-stage divider sets depth.
// A stalled result freezes the whole pipeline; bubbles are not squeezed out.
// Reset (rst, synchronous, active high) clears all valid bits and sets every
//   box register to zero; the tolerance path then settles through its registers.
module ray_box_intersection import rbi_pkg::*; #(
  parameter int FRACTION_BITS   = 16,
  parameter int TOLERANCE_SHIFT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ray_valid,
  output logic        ray_stall,
  input  ray_t        ray,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The whole pipeline moves together. It may move whenever the output
  // register is empty or its item is being taken this cycle.
  logic adv;

  assign adv       = !res_valid || !res_stall;
  assign ray_stall = !adv;

  // Box registers. Writes to indexes beyond the list are dropped.
  logic [2:0][31:0] box_min;
  logic [2:0][31:0] box_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min <= '0;
      box_max <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: box_min[0] <= cfg_data;
        REG_MIN_Y: box_min[1] <= cfg_data;
        REG_MIN_Z: box_min[2] <= cfg_data;
        REG_MAX_X: box_max[0] <= cfg_data;
        REG_MAX_Y: box_max[1] <= cfg_data;
        REG_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tolerance: the squared diagonal scaled down, then folded into widened
  // bounds per axis. The user must make box changes only while the block
  // is idle; the block does not enforce this. An item needs the bounds far
  // later than this path takes to settle, so it runs freely with no valid bits.
  logic [2:0][32:0]   ext;
  logic [2:0][65:0]   sq;
  logic [SW-1:0]      sum;
  logic [SW-1:0]      eps;
  logic [2:0][CW-1:0] bound_lo;
  logic [2:0][CW-1:0] bound_hi;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ext[i] <= ($signed(box_max[i]) < $signed(box_min[i]))
              ? 33'($signed(box_min[i])) - 33'($signed(box_max[i]))
              : 33'($signed(box_max[i])) - 33'($signed(box_min[i]));
      sq[i]  <= 66'(ext[i]) * 66'(ext[i]);
    end
    sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    for (int i = 0; i < 3; i++) begin
      bound_lo[i] <= CW'($signed(box_min[i])) - CW'(eps);
      bound_hi[i] <= CW'($signed(box_max[i])) + CW'(eps);
    end
  end

  assign eps = sum >> (FRACTION_BITS + TOLERANCE_SHIFT);

  logic   f_valid;
  front_t f_out;
  logic   d_valid;
  div_t   d_out;

  rbi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ray_valid),
    .ray       (ray),
    .box_min   (box_min),
    .box_max   (box_max),
    .out_valid (f_valid),
    .out       (f_out)
  );

  rbi_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .in        (f_out),
    .out_valid (d_valid),
    .out       (d_out)
  );

  rbi_check #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid),
    .in        (d_out),
    .bound_lo  (bound_lo),
    .bound_hi  (bound_hi),
    .out_valid (res_valid),
    .out       (res)
  );

`ifndef SYNTHESIS
  // With no entry plane the distance is reported as zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.entry_axis == AXIS_NONE |-> res.hit_distance == '0)
    else $error("no entry plane but nonzero distance");

  // Reset empties the output stage at once.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ verif/ray_box_intersection_tb.sv @@
`timescale 1ns / 1ps

import rbi_pkg::*;

// The scoreboard keeps its own copy of the box corners. It works out the expected
// entry plane, distance and hit flag for every ray that the block accepts.
class hit_scoreboard;

  longint box_lo[3];
  longint box_hi[3];
  res_t   expected_hits[$];
  int     errors;

  function new();
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] index, logic signed [31:0] value);
    case (index)
      REG_MIN_X: box_lo[0] = value;
      REG_MIN_Y: box_lo[1] = value;
      REG_MIN_Z: box_lo[2] = value;
      REG_MAX_X: box_hi[0] = value;
      REG_MAX_Y: box_hi[1] = value;
      REG_MAX_Z: box_hi[2] = value;
      default: ;
    endcase
  endfunction

  function longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Tolerance is the squared diagonal, scaled down. The sum of squares needs 67 bits.
  function longint widening();
    logic [66:0] sum;
    longint unsigned e;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      e = magnitude(box_hi[i] - box_lo[i]);
      sum = sum + 67'(e) * 67'(e);
    end
    return longint'(sum >> 26);
  endfunction

  function void note_ray(ray_t r);
    longint o[3], d[3], f, t, eps, h, p;
    longint unsigned af, ad, cur_f, cur_d, q, pm;
    int axis, in_slab, a;
    logic hit;
    res_t want;
    o[0] = r.origin_x;    o[1] = r.origin_y;    o[2] = r.origin_z;
    d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
    axis = -1;
    in_slab = 0;
    cur_f = 0;
    cur_d = 1;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      if (o[i] < box_lo[i]) begin
        f = o[i] - box_lo[i];
      end else if (o[i] > box_hi[i]) begin
        f = o[i] - box_hi[i];
      end else begin
        in_slab++;
        continue;
      end
      if (d[i] == 0) continue;
      af = magnitude(f);
      ad = magnitude(d[i]);
      // A later axis takes over only when its distance is strictly larger.
      if (axis < 0 || af * cur_d > cur_f * ad) begin
        q = (af << 16) / ad;
        if ((f < 0) == (d[i] < 0)) begin
          t = (q >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
        end else begin
          t = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
        end
        cur_f = af;
        cur_d = ad;
        axis = i;
      end
    end
    if (axis < 0) begin
      t = 0;
      hit = (in_slab == 3);
      want.entry_axis = AXIS_NONE;
    end else begin
      eps = widening();
      hit = 1'b1;
      for (int k = 1; k <= 2; k++) begin
        a = (axis + k) % 3;
        pm = (magnitude(t) * magnitude(d[a])) >> 16;
        p = ((t < 0) != (d[a] < 0)) ? -longint'(pm) : longint'(pm);
        h = o[a] + p;
        if (h < box_lo[a] - eps || h > box_hi[a] + eps) hit = 1'b0;
      end
      case (axis)
        0: want.entry_axis = AXIS_X;
        1: want.entry_axis = AXIS_Y;
        default: want.entry_axis = AXIS_Z;
      endcase
    end
    want.hit = hit;
    want.hit_distance = t[31:0];
    expected_hits.push_back(want);
  endfunction

  function void check_hit(res_t got);
    res_t want;
    if (expected_hits.size() == 0) begin
      $display("%0t: result with none expected: hit %0b t %0d axis %0d", $time,
               got.hit, got.hit_distance, got.entry_axis);
      errors++;
      return;
    end
    want = expected_hits.pop_front();
    if (got.hit !== want.hit) begin
      $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
      errors++;
    end
    if (got.hit_distance !== want.hit_distance) begin
      $display("%0t: hit_distance expected %0d actual %0d", $time,
               want.hit_distance, got.hit_distance);
      errors++;
    end
    if (got.entry_axis !== want.entry_axis) begin
      $display("%0t: entry_axis expected %0d actual %0d", $time,
               want.entry_axis, got.entry_axis);
      errors++;
    end
  endfunction
endclass

module ray_box_intersection_tb;
  import rbi_pkg::*;

  // One unit in Q16.16.
  localparam int ONE = 65536;
  // The run is cut off here. This leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  // The pipeline is 39 deep, and the tolerance path must settle after a write.
  localparam int SETTLE = 60;

  logic        clk;
  logic        rst;
  logic        ray_valid;
  logic        ray_stall;
  ray_t        ray;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  hit_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  logic signed [31:0] lo[3], hi[3];

  ray_box_intersection dut (
    .clk(clk), .rst(rst),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The monitors sample the handshakes at the clock edge. Each accepted ray adds
  // one expectation, and each accepted result is checked against the oldest one.
  always @(posedge clk) begin
    if (!rst && ray_valid && !ray_stall) sb.note_ray(ray);
    if (!rst && res_valid && !res_stall) sb.check_hit(res);
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_box_intersection: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] index, logic signed [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    sb.set_reg(index, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(logic signed [31:0] lx, logic signed [31:0] ly,
                         logic signed [31:0] lz, logic signed [31:0] hx,
                         logic signed [31:0] hy, logic signed [31:0] hz);
    lo[0] = lx; lo[1] = ly; lo[2] = lz;
    hi[0] = hx; hi[1] = hy; hi[2] = hz;
    cfg_write(REG_MIN_X, lx);
    cfg_write(REG_MIN_Y, ly);
    cfg_write(REG_MIN_Z, lz);
    cfg_write(REG_MAX_X, hx);
    cfg_write(REG_MAX_Y, hy);
    cfg_write(REG_MAX_Z, hz);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The sender may go idle for a while before each item. After that it holds the
  // item steady until the block takes it.
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      ray_valid <= 1'b0;
      @(posedge clk);
    end
    ray_valid <= 1'b1;
    ray <= r;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
  endtask

  // The sender stops and waits until every outstanding result has come back. Then
  // the block is idle and the registers may be written.
  task automatic drain();
    ray_valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.origin_x = ox;    r.origin_y = oy;    r.origin_z = oz;
    r.direction_x = dx; r.direction_y = dy; r.direction_z = dz;
    return r;
  endfunction

  // Origins fall mostly just outside, just inside or across the box. The rest
  // cover the full range.
  function automatic logic signed [31:0] pick_origin(int axis);
    logic signed [31:0] off;
    off = $urandom_range(0, 1 << $urandom_range(4, 24));
    case ($urandom_range(4))
      0: return lo[axis] - off;
      1: return hi[axis] + off;
      2: return lo[axis] + off;
      3: return hi[axis] - off;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_direction();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1: v = 0;
      2, 3, 4, 5: v = $urandom_range(1, 1 << $urandom_range(1, 20));
      6, 7, 8: v = $urandom;
      default: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh0000_0001;
    endcase
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    if ($urandom_range(9) < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.origin_x = pick_origin(0);
      r.origin_y = pick_origin(1);
      r.origin_z = pick_origin(2);
      r.direction_x = pick_direction();
      r.direction_y = pick_direction();
      r.direction_z = pick_direction();
    end
    return r;
  endfunction

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      send_ray(random_ray());
      // Quiet stretches break up the idling now and then.
      if (n % 100 == 50) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (n % 100 == 80) begin
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray = '0;
    res_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 3; i++) begin
      lo[i] = 0;
      hi[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    // At reset the box collapses to a point at the origin.
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(ONE, 0, 0, -ONE, 0, 0));
    drain();

    // The directed rays use a box from -10 to 10 on every axis.
    set_box(-10 * ONE, -10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE);
    // The origin is inside and no plane is a candidate.
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(ONE, -ONE, 2 * ONE, ONE, ONE, ONE));
    // The origin is outside on a parallel axis, so the ray misses.
    send_ray(make_ray(-20 * ONE, 0, 0, 0, ONE, 0));
    // A plain entry through a face on each axis.
    send_ray(make_ray(-20 * ONE, 0, 0, ONE, 0, 0));
    send_ray(make_ray(0, 20 * ONE, 0, 0, -2 * ONE, 0));
    send_ray(make_ray(0, 0, -30 * ONE, 0, 0, ONE / 2));
    // The ray points away from the box, so t is negative and still used.
    send_ray(make_ray(-20 * ONE, 0, 0, -ONE, 0, 0));
    // Two axes give the same distance, and the lower axis is kept.
    send_ray(make_ray(-20 * ONE, -20 * ONE, 0, ONE, ONE, 0));
    send_ray(make_ray(0, 20 * ONE, 20 * ONE, 0, -ONE, -ONE));
    // The hit point lies just inside the widened bound, then just outside it, then far outside.
    send_ray(make_ray(-20 * ONE, 11 * ONE, 0, ONE, 0, 0));
    send_ray(make_ray(-20 * ONE, 11 * ONE + ONE / 2, 0, ONE, 0, 0));
    send_ray(make_ray(-20 * ONE, 50 * ONE, 0, ONE, 0, 0));
    // A tiny direction makes the quotient saturate in both signs.
    send_ray(make_ray(32'sh8000_0000, 0, 0, 1, 1, 0));
    send_ray(make_ray(32'sh8000_0000, 0, 0, -1, 0, 0));
    // Extreme values on every field.
    send_ray(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1));
    // All three axes are candidates.
    send_ray(make_ray(-30 * ONE, 25 * ONE, -15 * ONE, 3 * ONE, -2 * ONE, ONE));
    drain();

    random_phase(230, 0, 0);

    // The box covers the full range on every axis.
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    random_phase(200, 55, 0);

    // On an inverted box no origin is inside any slab.
    set_box(5 * ONE, 3 * ONE, ONE, -5 * ONE, -3 * ONE, -ONE);
    random_phase(200, 0, 55);

    // A random box, with both sides idling.
    set_box(-$urandom_range(1 << 24), -$urandom_range(1 << 28), -$urandom_range(1 << 20),
            $urandom_range(1 << 24), $urandom_range(1 << 28), $urandom_range(1 << 20));
    random_phase(200, 30, 30);

    // A box flat in x and z, at the most negative x.
    set_box(32'sh8000_0000, -ONE, 0, 32'sh8000_0000, ONE, 0);
    random_phase(200, 55, 55);

    // A fully random box.
    set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(200, 30, 30);

    if (sb.errors == 0) begin
      $display("ray_box_intersection: match");
    end else begin
      $display("ray_box_intersection: mismatch");
    end
    $finish;
  end

endmodule

@@ ray_box_intersection.f @@
sv/rbi_pkg.sv
sv/rbi_front.sv
sv/rbi_div.sv
sv/rbi_check.sv
sv/ray_box_intersection.sv
verif/ray_box_intersection_tb.sv
